@@ sv/psl_pkg.sv @@
// psl_pkg: shared widths, codes, control word layout and microcode rom
// for the per-symbol position list index. no dependencies.
`default_nettype none

package psl_pkg;

  localparam int WINDOW_ENTRIES = 2048;
  localparam int POSITION_BITS  = 32;
  localparam int HEAD_COUNT     = 256;
  localparam int ENTRY_COUNT    = WINDOW_ENTRIES + HEAD_COUNT;

  localparam int REQ_W    = 2;
  localparam int SYM_W    = 8;
  localparam int POS_W    = 32;
  localparam int IDX_W    = 12;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = $clog2(WINDOW_ENTRIES);
  localparam int HEAD_W   = $clog2(HEAD_COUNT);
  localparam int CNT_W    = $clog2(WINDOW_ENTRIES + 1);
  localparam int STEP_W   = 5;

  // stream packing
  localparam int IN_SYM_LSB   = REQ_W;
  localparam int IN_POS_LSB   = IN_SYM_LSB + SYM_W;
  localparam int IN_IDX_LSB   = IN_POS_LSB + POS_W;
  localparam int IN_FIELD_W   = IN_IDX_LSB + IDX_W;
  localparam int IN_W         = ((IN_FIELD_W + 7) / 8) * 8;
  localparam int OUT_HEAD_LSB = IDX_W;
  localparam int OUT_NXT_LSB  = OUT_HEAD_LSB + 1;
  localparam int OUT_PRV_LSB  = OUT_NXT_LSB + IDX_W;
  localparam int OUT_POS_LSB  = OUT_PRV_LSB + IDX_W;
  localparam int OUT_ST_LSB   = OUT_POS_LSB + POS_W;
  localparam int OUT_FIELD_W  = OUT_ST_LSB + STATUS_W;
  localparam int OUT_W        = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD      = OUT_W - OUT_FIELD_W;

  // request codes
  localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FIRST  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD     = 2'd2;

  typedef logic [STEP_W-1:0] step_t;

  // program steps
  localparam step_t S_ADD_POP    = 5'd0;
  localparam step_t S_ADD_LATCH  = 5'd1;
  localparam step_t S_ADD_NODE   = 5'd2;
  localparam step_t S_ADD_LINK   = 5'd3;
  localparam step_t S_REM_HEAD   = 5'd4;
  localparam step_t S_REM_TAIL   = 5'd5;
  localparam step_t S_REM_READ   = 5'd6;
  localparam step_t S_REM_CHECK  = 5'd7;
  localparam step_t S_REM_UNLINK = 5'd8;
  localparam step_t S_FST_HEAD   = 5'd9;
  localparam step_t S_FST_NODE   = 5'd10;
  localparam step_t S_FST_READ   = 5'd11;
  localparam step_t S_FST_DESC   = 5'd12;
  localparam step_t S_RD_ENT     = 5'd13;
  localparam step_t S_RD_READ    = 5'd14;
  localparam step_t S_RD_DESC    = 5'd15;
  localparam step_t S_END        = 5'd16;

  typedef enum logic [2:0] {
    ENT_KEEP, ENT_FS, ENT_NL, ENT_PL, ENT_IDX
  } ent_src_e;

  typedef enum logic [1:0] {
    LAT_NONE, LAT_ADD, LAT_DESC
  } lat_e;

  typedef enum logic [1:0] {
    WR_NONE, WR_ADD_NODE, WR_ADD_LINK, WR_UNLINK
  } wr_e;

  typedef enum logic [1:0] {
    C_NONE, C_STACK_EMPTY, C_TAIL_BAD
  } cond_e;

  typedef struct packed {
    logic                rd_ent;     // link reads at working entry, else at head; position reads always at entry
    logic                pop;        // pop the free stack
    ent_src_e            ent_src;
    lat_e                lat;
    wr_e                 wr;
    cond_e               cond;
    step_t               target;
    logic [STATUS_W-1:0] jmp_status;
    logic                done;
  } ctrl_t;

  typedef struct packed {
    logic stack_empty;
    logic tail_bad;
  } flags_t;

  typedef struct packed {
    logic [IDX_W-1:0]    index;
    logic                is_head;
    logic [IDX_W-1:0]    next_link;
    logic [IDX_W-1:0]    prev_link;
    logic [POS_W-1:0]    stored_position;
    logic [STATUS_W-1:0] status;
  } result_t;

  function automatic step_t entry_step(input logic [REQ_W-1:0] req);
    step_t s;
    unique case (req)
      REQ_ADD:    s = S_ADD_POP;
      REQ_REMOVE: s = S_REM_HEAD;
      REQ_FIRST:  s = S_FST_HEAD;
      REQ_READ:   s = S_RD_ENT;
      default:    s = S_END;
    endcase
    return s;
  endfunction

  function automatic logic cond_hit(input cond_e c, input flags_t f);
    logic h;
    unique case (c)
      C_NONE:        h = 1'b0;
      C_STACK_EMPTY: h = f.stack_empty;
      C_TAIL_BAD:    h = f.tail_bad;
      default:       h = 1'b0;
    endcase
    return h;
  endfunction

  function automatic ctrl_t ucode(input step_t step);
    ctrl_t c;
    c.rd_ent     = 1'b0;
    c.pop        = 1'b0;
    c.ent_src    = ENT_KEEP;
    c.lat        = LAT_NONE;
    c.wr         = WR_NONE;
    c.cond       = C_NONE;
    c.target     = S_END;
    c.jmp_status = ST_OK;
    c.done       = 1'b0;
    unique case (step)
      S_ADD_POP: begin
        c.pop        = 1'b1;
        c.cond       = C_STACK_EMPTY;
        c.jmp_status = ST_NO_FREE;
      end
      S_ADD_LATCH: begin
        c.ent_src = ENT_FS;
        c.lat     = LAT_ADD;
      end
      S_ADD_NODE:   c.wr = WR_ADD_NODE;
      S_ADD_LINK: begin
        c.wr   = WR_ADD_LINK;
        c.done = 1'b1;
      end
      S_REM_HEAD:   c.rd_ent = 1'b0;
      S_REM_TAIL:   c.ent_src = ENT_PL;
      S_REM_READ:   c.rd_ent = 1'b1;
      S_REM_CHECK: begin
        c.lat        = LAT_DESC;
        c.cond       = C_TAIL_BAD;
        c.jmp_status = ST_BAD;
      end
      S_REM_UNLINK: begin
        c.wr   = WR_UNLINK;
        c.done = 1'b1;
      end
      S_FST_HEAD:   c.rd_ent = 1'b0;
      S_FST_NODE:   c.ent_src = ENT_NL;
      S_FST_READ:   c.rd_ent = 1'b1;
      S_FST_DESC: begin
        c.lat  = LAT_DESC;
        c.done = 1'b1;
      end
      S_RD_ENT:     c.ent_src = ENT_IDX;
      S_RD_READ:    c.rd_ent = 1'b1;
      S_RD_DESC: begin
        c.lat  = LAT_DESC;
        c.done = 1'b1;
      end
      S_END:        c.done = 1'b1;
      default:      c.done = 1'b1;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ sv/psl_sequencer.sv @@
// psl_sequencer: step counter, microcode rom lookup and conditional jumps.
// depends on psl_pkg.
`default_nettype none

module psl_sequencer (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [psl_pkg::REQ_W-1:0]  req_type_i,
  input  wire psl_pkg::flags_t            flags_i,
  input  wire logic                       out_blocked_i,
  output      logic                       busy_o,
  output      logic                       go_o,
  output      logic                       taken_o,
  output      psl_pkg::ctrl_t             ctrl_o
);

  logic           busy_q, busy_d;
  psl_pkg::step_t step_q, step_d;
  psl_pkg::ctrl_t ctrl;
  logic           go;
  logic           taken;

  assign ctrl  = psl_pkg::ucode(step_q);
  // hold the final step until the output register can take the result
  assign go    = busy_q && !(ctrl.done && out_blocked_i);
  assign taken = psl_pkg::cond_hit(ctrl.cond, flags_i);

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = psl_pkg::entry_step(req_type_i);
    end else if (go) begin
      if (ctrl.done) begin
        busy_d = 1'b0;
      end else if (taken) begin
        step_d = ctrl.target;
      end else begin
        step_d = step_q + psl_pkg::step_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= psl_pkg::S_END;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  assign busy_o  = busy_q;
  assign go_o    = go;
  assign taken_o = taken;
  assign ctrl_o  = ctrl;

endmodule

`default_nettype wire

@@ sv/psl_datapath.sv @@
// psl_datapath: link memories, position memory, free slot stack and the
// working registers driven by the control word. depends on psl_pkg.
`default_nettype none

module psl_datapath (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [psl_pkg::SYM_W-1:0] symbol_i,
  input  wire logic [psl_pkg::POS_W-1:0] position_i,
  input  wire logic [psl_pkg::IDX_W-1:0] node_index_i,
  input  wire logic                      go_i,
  input  wire logic                      taken_i,
  input  wire psl_pkg::ctrl_t            ctrl_i,
  output      psl_pkg::flags_t           flags_o,
  output      psl_pkg::result_t          result_o
);

  localparam int IDX_W  = psl_pkg::IDX_W;
  localparam int POS_W  = psl_pkg::POS_W;
  localparam int SLOT_W = psl_pkg::SLOT_W;
  localparam int HEAD_W = psl_pkg::HEAD_W;
  localparam int CNT_W  = psl_pkg::CNT_W;
  localparam logic [IDX_W-1:0] WIN_IDX   = IDX_W'(psl_pkg::WINDOW_ENTRIES);
  localparam logic [IDX_W-1:0] ENTRY_IDX = IDX_W'(psl_pkg::ENTRY_COUNT);
  localparam logic [CNT_W-1:0] WIN_CNT   = CNT_W'(psl_pkg::WINDOW_ENTRIES);

  // memories
  logic [IDX_W-1:0]  nl_mem  [psl_pkg::ENTRY_COUNT];
  logic [IDX_W-1:0]  pl_mem  [psl_pkg::ENTRY_COUNT];
  logic [POS_W-1:0]  pos_mem [psl_pkg::WINDOW_ENTRIES];
  logic [SLOT_W-1:0] fs_mem  [psl_pkg::WINDOW_ENTRIES];

  // heads read as themselves until their first write
  logic [psl_pkg::HEAD_COUNT-1:0] nl_hv_q, pl_hv_q;

  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] wm_q, wm_d;

  // working registers
  logic [IDX_W-1:0]    head_q, head_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [IDX_W-1:0]    ent_q, ent_d;
  logic [IDX_W-1:0]    nxt_q, nxt_d;
  logic [IDX_W-1:0]    prv_q, prv_d;
  logic [POS_W-1:0]    spos_q, spos_d;
  logic [psl_pkg::STATUS_W-1:0] status_q, status_d;

  // read side
  logic [IDX_W-1:0]  ra, ra_safe, ra_q;
  logic [HEAD_W-1:0] ra_head;
  logic              ra_is_head;
  logic [IDX_W-1:0]  nl_rd_q, pl_rd_q, nl_rd, pl_rd;
  logic              nl_dflt_q, pl_dflt_q;
  logic [POS_W-1:0]  pos_rd_q;
  logic              pop;
  logic [SLOT_W-1:0] fa, fa_q, fs_rd_q, fs_rd;
  logic              fs_dflt_q;

  // write side
  logic              nl_we, pl_we, pos_we, fs_we;
  logic [IDX_W-1:0]  nl_wa, nl_wd, pl_wa, pl_wd;
  logic [SLOT_W-1:0] pos_wa, fs_wa, fs_wd;
  logic [POS_W-1:0]  pos_wd;
  logic              push;

  logic ent_in_range, ent_is_head;

  assign ra         = ctrl_i.rd_ent ? ent_q : head_q;
  assign ra_safe    = (ra < ENTRY_IDX) ? ra : '0;
  assign ra_is_head = (ra >= WIN_IDX);
  assign ra_head    = HEAD_W'(ra - WIN_IDX);

  assign nl_rd = nl_dflt_q ? ra_q : nl_rd_q;
  assign pl_rd = pl_dflt_q ? ra_q : pl_rd_q;

  assign pop   = go_i && ctrl_i.pop && !taken_i;
  assign fa    = SLOT_W'(count_q - CNT_W'(1));
  // below the low-water mark the stack still holds its reset contents
  assign fs_rd = fs_dflt_q ? fa_q : fs_rd_q;

  assign ent_in_range = (ent_q < ENTRY_IDX);
  assign ent_is_head  = (ent_q >= WIN_IDX);

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      nl_rd_q   <= nl_mem[ra_safe];
      pl_rd_q   <= pl_mem[ra_safe];
      pos_rd_q  <= pos_mem[ent_q[SLOT_W-1:0]];
      nl_dflt_q <= ra_is_head && !nl_hv_q[ra_head];
      pl_dflt_q <= ra_is_head && !pl_hv_q[ra_head];
      ra_q      <= ra;
    end
    if (pop) begin
      fs_rd_q   <= fs_mem[fa];
      fs_dflt_q <= (CNT_W'(fa) < wm_q);
      fa_q      <= fa;
    end
  end

  // write port selection
  always_comb begin
    nl_we  = 1'b0;
    pl_we  = 1'b0;
    pos_we = 1'b0;
    nl_wa  = ent_q;
    nl_wd  = nxt_q;
    pl_wa  = ent_q;
    pl_wd  = prv_q;
    pos_wa = ent_q[SLOT_W-1:0];
    pos_wd = spos_q;
    if (go_i) begin
      case (ctrl_i.wr)
        psl_pkg::WR_ADD_NODE: begin
          nl_we  = 1'b1;
          pl_we  = 1'b1;
          pos_we = 1'b1;
        end
        psl_pkg::WR_ADD_LINK: begin
          nl_we = 1'b1;
          nl_wa = head_q;
          nl_wd = ent_q;
          pl_we = 1'b1;
          pl_wa = nxt_q;
          pl_wd = ent_q;
        end
        psl_pkg::WR_UNLINK: begin
          nl_we = 1'b1;
          nl_wa = prv_q;
          nl_wd = nxt_q;
          pl_we = 1'b1;
          pl_wa = nxt_q;
          pl_wd = prv_q;
        end
        default: ;
      endcase
    end
  end

  assign push  = go_i && (ctrl_i.wr == psl_pkg::WR_UNLINK);
  assign fs_we = push && (count_q < WIN_CNT);
  assign fs_wa = count_q[SLOT_W-1:0];
  assign fs_wd = ent_q[SLOT_W-1:0];

  always_ff @(posedge clk_i) begin
    if (nl_we) begin
      nl_mem[nl_wa] <= nl_wd;
    end
    if (pl_we) begin
      pl_mem[pl_wa] <= pl_wd;
    end
    if (pos_we) begin
      pos_mem[pos_wa] <= pos_wd;
    end
    if (fs_we) begin
      fs_mem[fs_wa] <= fs_wd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nl_hv_q <= '0;
      pl_hv_q <= '0;
    end else begin
      if (nl_we && (nl_wa >= WIN_IDX)) begin
        nl_hv_q[HEAD_W'(nl_wa - WIN_IDX)] <= 1'b1;
      end
      if (pl_we && (pl_wa >= WIN_IDX)) begin
        pl_hv_q[HEAD_W'(pl_wa - WIN_IDX)] <= 1'b1;
      end
    end
  end

  // stack count and low-water mark
  always_comb begin
    count_d = count_q;
    wm_d    = wm_q;
    if (pop) begin
      count_d = count_q - CNT_W'(1);
      if (CNT_W'(fa) < wm_q) begin
        wm_d = CNT_W'(fa);
      end
    end else if (fs_we) begin
      count_d = count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= WIN_CNT;
      wm_q    <= WIN_CNT;
    end else begin
      count_q <= count_d;
      wm_q    <= wm_d;
    end
  end

  // working registers
  always_comb begin
    head_d   = head_q;
    pos_d    = pos_q;
    idx_d    = idx_q;
    ent_d    = ent_q;
    nxt_d    = nxt_q;
    prv_d    = prv_q;
    spos_d   = spos_q;
    status_d = status_q;
    if (start_i) begin
      head_d   = WIN_IDX + IDX_W'(symbol_i);
      pos_d    = position_i;
      idx_d    = node_index_i;
      ent_d    = '0;
      nxt_d    = '0;
      prv_d    = '0;
      spos_d   = '0;
      status_d = psl_pkg::ST_OK;
    end else if (go_i) begin
      case (ctrl_i.ent_src)
        psl_pkg::ENT_FS:  ent_d = IDX_W'(fs_rd);
        psl_pkg::ENT_NL:  ent_d = nl_rd;
        psl_pkg::ENT_PL:  ent_d = pl_rd;
        psl_pkg::ENT_IDX: ent_d = idx_q;
        default: ;
      endcase
      case (ctrl_i.lat)
        psl_pkg::LAT_ADD: begin
          nxt_d  = nl_rd;
          prv_d  = head_q;
          spos_d = pos_q;
        end
        psl_pkg::LAT_DESC: begin
          nxt_d  = ent_in_range ? nl_rd : '0;
          prv_d  = ent_in_range ? pl_rd : '0;
          spos_d = ent_is_head ? '0 : pos_rd_q;
        end
        default: ;
      endcase
      if (taken_i) begin
        status_d = ctrl_i.jmp_status;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    head_q   <= head_d;
    pos_q    <= pos_d;
    idx_q    <= idx_d;
    ent_q    <= ent_d;
    nxt_q    <= nxt_d;
    prv_q    <= prv_d;
    spos_q   <= spos_d;
    status_q <= status_d;
  end

  assign flags_o.stack_empty = (count_q == '0);
  assign flags_o.tail_bad    = ent_is_head || (pos_rd_q != pos_q);

  assign result_o.index           = ent_d;
  assign result_o.is_head         = (ent_d >= WIN_IDX);
  assign result_o.next_link       = nxt_d;
  assign result_o.prev_link       = prv_d;
  assign result_o.stored_position = spos_d;
  assign result_o.status          = status_d;

endmodule

`default_nettype wire

@@ sv/per_symbol_position_lists.sv @@
// per_symbol_position_lists: top level of the per-byte position list index.
// depends on psl_pkg, psl_sequencer and psl_datapath.
//
// usage: one request item in on the s_axis channel, one result item out on
// m_axis for every request. add links a position at the front of its byte's
// list and returns the slot taken; remove unlinks the oldest node of a byte
// after checking its position and returns the freed slot; the two queries
// return a byte's first node or one entry's links and position.
// each item runs through a short microcode program, one step per cycle
// while the final step is not held, with every step doing at most one read
// and one write per memory.
// the result sits in the output register the cycle after the last step.
// the next item is taken the cycle after the program has finished, even
// while the result still waits; if the receiver stalls with a result
// pending, the next item holds in its last step until the output register
// frees.
// after reset every list is empty and every slot is on the free stack; no
// clearing pass is needed, items are taken from the first cycle on.
`default_nettype none

module per_symbol_position_lists (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_axis_tvalid_i,
  output      logic                        s_axis_tready_o,
  // req_type[1:0], symbol[9:2], position[41:10], node_index[53:42], zero pad
  input  wire logic [psl_pkg::IN_W-1:0]    s_axis_tdata_i,
  output      logic                        m_axis_tvalid_o,
  input  wire logic                        m_axis_tready_i,
  // result_index[11:0], result_is_head[12], next_link[24:13], prev_link[36:25],
  // stored_position[68:37], status[70:69], zero pad
  output      logic [psl_pkg::OUT_W-1:0]   m_axis_tdata_o
);

  logic             busy;
  logic             go;
  logic             taken;
  logic             start;
  logic             out_blocked;
  psl_pkg::ctrl_t   ctrl;
  psl_pkg::flags_t  flags;
  psl_pkg::result_t result;
  psl_pkg::result_t res_q;
  logic             out_valid_q, out_valid_d;
  logic             finish;

  assign s_axis_tready_o = !busy;
  assign start           = s_axis_tvalid_i && !busy;
  assign out_blocked     = out_valid_q && !m_axis_tready_i;
  assign finish          = go && ctrl.done;

  psl_sequencer u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .req_type_i    (s_axis_tdata_i[psl_pkg::REQ_W-1:0]),
    .flags_i       (flags),
    .out_blocked_i (out_blocked),
    .busy_o        (busy),
    .go_o          (go),
    .taken_o       (taken),
    .ctrl_o        (ctrl)
  );

  psl_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .symbol_i     (s_axis_tdata_i[psl_pkg::IN_SYM_LSB +: psl_pkg::SYM_W]),
    .position_i   (s_axis_tdata_i[psl_pkg::IN_POS_LSB +: psl_pkg::POS_W]),
    .node_index_i (s_axis_tdata_i[psl_pkg::IN_IDX_LSB +: psl_pkg::IDX_W]),
    .go_i         (go),
    .taken_i      (taken),
    .ctrl_i       (ctrl),
    .flags_o      (flags),
    .result_o     (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (finish) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      res_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{psl_pkg::OUT_PAD{1'b0}}, res_q.status, res_q.stored_position,
                            res_q.prev_link, res_q.next_link, res_q.is_head, res_q.index};

endmodule

`default_nettype wire

@@ sv/psl_checker.sv @@
// psl_checker: port-level checks on the result stream of the list index,
// bound to per_symbol_position_lists. depends on psl_pkg.
`default_nettype none

module psl_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      m_axis_tvalid_o,
  input wire logic                      m_axis_tready_i,
  input wire logic [psl_pkg::OUT_W-1:0] m_axis_tdata_o
);

  logic [psl_pkg::IDX_W-1:0]    r_index;
  logic                         r_head;
  logic [psl_pkg::STATUS_W-1:0] r_status;

  assign r_index  = m_axis_tdata_o[psl_pkg::IDX_W-1:0];
  assign r_head   = m_axis_tdata_o[psl_pkg::OUT_HEAD_LSB];
  assign r_status = m_axis_tdata_o[psl_pkg::OUT_ST_LSB +: psl_pkg::STATUS_W];

  // head flag must agree with the index range
  a_head_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      (r_head == (r_index >= psl_pkg::IDX_W'(psl_pkg::WINDOW_ENTRIES))))
    else $error("head flag does not match result index");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      (r_status == psl_pkg::ST_OK || r_status == psl_pkg::ST_NO_FREE ||
       r_status == psl_pkg::ST_BAD))
    else $error("unknown status code");

  // a failed add reports nothing but its status
  a_no_free_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && r_status == psl_pkg::ST_NO_FREE) |->
      (m_axis_tdata_o[psl_pkg::OUT_ST_LSB-1:0] == '0))
    else $error("failed add carries nonzero fields");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("stalled result item changed");

endmodule

bind per_symbol_position_lists psl_checker u_psl_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire
